FILE: hw/rtl/assert_macros.svh
// assertion helpers, sampled on clk and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define AMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AMP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AMP_ASSERT(lbl, prop, msg)

`define AMP_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: hw/rtl/amp_pkg.sv
`timescale 1ns / 1ps

package amp_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int ATT_BITS   = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

    typedef logic signed [20:0] mval_t;
    typedef logic signed [42:0] cval_t;
    typedef logic signed [31:0] word_t;
    typedef logic signed [63:0] acc_t;
    typedef logic signed [32:0] opnd_t;

    localparam acc_t  A_MAX    = 64'sd524287;
    localparam acc_t  A_MIN    = -64'sd524288;
    localparam acc_t  ATT_MAX  = (64'sd1 <<< (ATT_BITS - 1)) - 64'sd1;
    localparam acc_t  ATT_MIN  = -(64'sd1 <<< (ATT_BITS - 1));
    localparam mval_t TWO_Q16  = 21'sd131072;
    localparam mval_t FOUR_Q16 = 21'sd262144;
    localparam word_t ONE_Q30  = 32'sh4000_0000;
    localparam word_t Q30_MAX  = 32'sh7fff_ffff;
    localparam word_t Q30_MIN  = 32'sh8000_0000;
    localparam logic [30:0] DT_RESET = 31'd6554;
    localparam logic [3:0]  LAST_ENT = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_WB,
        ST_DIVS,
        ST_DIVW,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PH_A,
        PH_C,
        PH_D,
        PH_X,
        PH_R
    } phase_t;

    typedef struct packed {
        logic en;
        logic clr;
        logic neg;
        logic shl;
        logic shr;
    } mac_ctl_t;

    typedef struct packed {
        logic       idle;
        logic       issue;
        logic       wb;
        logic       div_start;
        logic       p_we;
        logic       done_load;
        phase_t     phase;
        logic [3:0] ent;
        logic [2:0] term;
    } seq_ctl_t;

    typedef struct packed {
        logic [3:0] ia;
        logic [3:0] ib;
        logic       neg;
    } cof_sel_t;

    function automatic logic [1:0] ent_row(input logic [3:0] e);
        logic [1:0] r;
        case (e)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] ent_col(input logic [3:0] e);
        logic [1:0] c;
        case (e)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] mat_idx(input logic [1:0] r, input logic [1:0] c);
        return {r, 2'b00} - {2'b00, r} + {2'b00, c};
    endfunction

    // adjugate entry (r,q) is the cofactor of M at (q,r)
    function automatic cof_sel_t cof_term(input logic [3:0] e, input logic t);
        logic [1:0] r;
        logic [1:0] q;
        logic [1:0] ra;
        logic [1:0] rb;
        logic [1:0] cx;
        logic [1:0] cy;
        logic       s;
        cof_sel_t   sel;
        r  = ent_row(e);
        q  = ent_col(e);
        ra = (q == 2'd0) ? 2'd1 : 2'd0;
        rb = (q == 2'd2) ? 2'd1 : 2'd2;
        cx = (r == 2'd0) ? 2'd1 : 2'd0;
        cy = (r == 2'd2) ? 2'd1 : 2'd2;
        s  = r[0] ^ q[0];
        if (!t)
        begin
            sel.ia  = mat_idx(ra, cx);
            sel.ib  = mat_idx(rb, cy);
            sel.neg = s;
        end
        else
        begin
            sel.ia  = mat_idx(rb, cx);
            sel.ib  = mat_idx(ra, cy);
            sel.neg = !s;
        end
        return sel;
    endfunction

    function automatic logic [2:0] phase_last_term(input phase_t ph);
        logic [2:0] n;
        case (ph)
            PH_A:    n = 3'd0;
            PH_C:    n = 3'd1;
            PH_D:    n = 3'd5;
            PH_X:    n = 3'd5;
            PH_R:    n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: hw/rtl/amp_in_if.sv
`timescale 1ns / 1ps

interface amp_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] omega_00;
    logic signed [31:0] omega_01;
    logic signed [31:0] omega_02;
    logic signed [31:0] omega_10;
    logic signed [31:0] omega_11;
    logic signed [31:0] omega_12;
    logic signed [31:0] omega_20;
    logic signed [31:0] omega_21;
    logic signed [31:0] omega_22;

    modport source (
        output valid, omega_00, omega_01, omega_02, omega_10, omega_11, omega_12,
               omega_20, omega_21, omega_22,
        input  ready
    );

    modport sink (
        input  valid, omega_00, omega_01, omega_02, omega_10, omega_11, omega_12,
               omega_20, omega_21, omega_22,
        output ready
    );
endinterface

FILE: hw/rtl/amp_out_if.sv
`timescale 1ns / 1ps

interface amp_out_if;
    logic        valid;
    logic        ready;
    logic        updated_ok;
    logic signed [31:0] att_00;
    logic signed [31:0] att_01;
    logic signed [31:0] att_02;
    logic signed [31:0] att_10;
    logic signed [31:0] att_11;
    logic signed [31:0] att_12;
    logic signed [31:0] att_20;
    logic signed [31:0] att_21;
    logic signed [31:0] att_22;

    modport source (
        output valid, updated_ok, att_00, att_01, att_02, att_10, att_11, att_12,
               att_20, att_21, att_22,
        input  ready
    );

    modport sink (
        input  valid, updated_ok, att_00, att_01, att_02, att_10, att_11, att_12,
               att_20, att_21, att_22,
        output ready
    );
endinterface

FILE: hw/rtl/amp_mac.sv
`timescale 1ns / 1ps

module amp_mac
    import amp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mac_ctl_t ctl,
    input  opnd_t    op_a,
    input  opnd_t    op_b,
    output acc_t     acc
);

    logic signed [65:0] prod_reg;
    mac_ctl_t           ctl_reg;
    acc_t               acc_reg;
    acc_t               acc_next;
    acc_t               term;
    acc_t               p64;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        p64 = prod_reg[63:0];
        if (ctl_reg.shl)
        begin
            term = p64 <<< 21;
        end
        else if (ctl_reg.shr)
        begin
            term = p64 >>> 30;
        end
        else
        begin
            term = p64;
        end
        if (ctl_reg.neg)
        begin
            term = -term;
        end
        if (ctl_reg.en)
        begin
            acc_next = (ctl_reg.clr ? 64'sd0 : acc_reg) + term;
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    assign acc = acc_reg;

endmodule

FILE: hw/rtl/amp_div.sv
`timescale 1ns / 1ps

module amp_div
    import amp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  acc_t  num,
    input  acc_t  den,
    output logic  busy,
    output word_t quo
);

    logic        busy_reg;
    logic        busy_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [30:0] mag_reg;
    logic        neg_reg;
    logic        sat_reg;
    logic [63:0] ux;
    logic [63:0] ud;
    logic        ge;
    logic [63:0] r2;

    assign ux = num[63] ? 64'(-num) : 64'(num);
    assign ud = den[63] ? 64'(-den) : 64'(den);
    assign ge = rem_reg >= den_reg;
    assign r2 = ge ? (rem_reg - den_reg) : rem_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            // quotient of two or more saturates at once
            busy_next = !({1'b0, ux} >= {ud, 1'b0});
            cnt_next  = 5'd31;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= ux;
            den_reg <= ud;
            mag_reg <= '0;
            neg_reg <= num[63] ^ den[63];
            sat_reg <= {1'b0, ux} >= {ud, 1'b0};
        end
        else if (busy_reg)
        begin
            rem_reg <= {r2[62:0], 1'b0};
            mag_reg <= {mag_reg[29:0], ge};
        end
    end

    always_comb
    begin
        if (sat_reg)
        begin
            quo = neg_reg ? Q30_MIN : Q30_MAX;
        end
        else
        begin
            quo = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
        end
    end

    assign busy = busy_reg;

endmodule

FILE: hw/rtl/amp_seq.sv
`timescale 1ns / 1ps

module amp_seq
    import amp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_fire,
    input  logic     div_busy,
    input  logic     det_zero,
    input  logic     out_free,
    output seq_ctl_t ctl
);

    state_t     state_reg;
    state_t     state_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [3:0] ent_reg;
    logic [3:0] ent_next;
    logic [2:0] term_reg;
    logic [2:0] term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_A;
            ent_reg   <= '0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ent_reg   <= ent_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        ent_next   = ent_reg;
        term_next  = term_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_ISSUE;
                    phase_next = PH_A;
                    ent_next   = '0;
                    term_next  = '0;
                end
            end
            ST_ISSUE:
            begin
                if (term_reg == phase_last_term(phase_reg))
                begin
                    state_next = ST_WAIT;
                    term_next  = '0;
                end
                else
                begin
                    term_next = term_reg + 3'd1;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                case (phase_reg)
                    PH_X:
                    begin
                        state_next = ST_DIVS;
                    end
                    PH_D:
                    begin
                        if (det_zero)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_ISSUE;
                            phase_next = PH_X;
                            ent_next   = '0;
                        end
                    end
                    default:
                    begin
                        if (ent_reg != LAST_ENT)
                        begin
                            state_next = ST_ISSUE;
                            ent_next   = ent_reg + 4'd1;
                        end
                        else
                        begin
                            ent_next = '0;
                            case (phase_reg)
                                PH_A:
                                begin
                                    state_next = ST_ISSUE;
                                    phase_next = PH_C;
                                end
                                PH_C:
                                begin
                                    state_next = ST_ISSUE;
                                    phase_next = PH_D;
                                end
                                default:
                                begin
                                    state_next = ST_DONE;
                                end
                            endcase
                        end
                    end
                endcase
            end
            ST_DIVS:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (!div_busy)
                begin
                    state_next = ST_ISSUE;
                    if (ent_reg == LAST_ENT)
                    begin
                        phase_next = PH_R;
                        ent_next   = '0;
                    end
                    else
                    begin
                        ent_next = ent_reg + 4'd1;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.idle      = state_reg == ST_IDLE;
        ctl.issue     = state_reg == ST_ISSUE;
        ctl.wb        = state_reg == ST_WB;
        ctl.div_start = state_reg == ST_DIVS;
        ctl.p_we      = (state_reg == ST_DIVW) && !div_busy;
        ctl.done_load = (state_reg == ST_DONE) && out_free;
        ctl.phase     = phase_reg;
        ctl.ent       = ent_reg;
        ctl.term      = term_reg;
    end

endmodule

FILE: hw/rtl/attitude_matrix_pade_update.sv
`timescale 1ns / 1ps
// Cayley attitude update: each rate item W (Q16.16) forms M = 2I - W*dt and
// N = 2I + W*dt, inverts M through its adjugate and determinant, and turns
// the stored attitude R (Q2.30, identity after reset) into R*N*adj(M)/det.
// A zero determinant gives updated_ok 0 and the attitude kept. All products
// go through one 33x33 multiply-accumulate unit and the nine quotients
// through one restoring divider at one bit a cycle. A saturated quotient ends
// its division at once, and a singular item skips the divisions and the
// remaining products. The block takes no new item until the previous one has
// been handed to the output register.

`include "assert_macros.svh"

module attitude_matrix_pade_update
    import amp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    amp_in_if.sink      rate,
    amp_out_if.source   attitude
);

    logic [30:0] dt_reg;
    word_t       omega_reg [0:8];
    mval_t       ma_reg    [0:8];
    mval_t       mb_reg    [0:8];
    cval_t       c_reg     [0:8];
    word_t       p_reg     [0:8];
    word_t       att_reg   [0:8];
    word_t       nr_reg    [0:8];
    word_t       out_att_reg [0:8];
    acc_t        d_reg;
    logic        ok_reg;
    logic        out_ok_reg;
    logic        out_valid_reg;

    seq_ctl_t    seq;
    mac_ctl_t    mctl;
    opnd_t       op_a;
    opnd_t       op_b;
    acc_t        acc;
    logic        div_busy;
    word_t       quo;
    logic        in_fire;
    logic        out_free;
    logic        det_zero;

    logic [1:0]  row;
    logic [1:0]  col;
    logic [1:0]  kk;
    cof_sel_t    cs;
    logic [3:0]  ma_addr;
    logic [3:0]  c_addr;
    mval_t       ma_rd;
    cval_t       c_rd;
    mval_t       n_val;
    opnd_t       c_half;
    acc_t        a_full;
    logic signed [19:0] a_sat;
    mval_t       m_new;
    word_t       r_new;

    assign in_fire    = rate.valid && rate.ready;
    assign rate.ready = seq.idle;
    assign out_free   = !out_valid_reg || attitude.ready;
    assign det_zero   = acc == 64'sd0;

    amp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .div_busy (div_busy),
        .det_zero (det_zero),
        .out_free (out_free),
        .ctl      (seq)
    );

    amp_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    amp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (seq.div_start),
        .num   (acc),
        .den   (d_reg),
        .busy  (div_busy),
        .quo   (quo)
    );

    // operand selection
    always_comb
    begin
        row     = ent_row(seq.ent);
        col     = ent_col(seq.ent);
        cs      = cof_term(seq.ent, seq.term[0]);
        kk      = (seq.phase == PH_R) ? seq.term[1:0] : seq.term[2:1];
        case (seq.phase)
            PH_C:    ma_addr = cs.ia;
            PH_D:    ma_addr = mat_idx(2'd0, kk);
            default: ma_addr = mat_idx(row, kk);
        endcase
        c_addr  = (seq.phase == PH_D) ? mat_idx(kk, 2'd0) : mat_idx(kk, col);
        ma_rd   = ma_reg[ma_addr];
        c_rd    = c_reg[c_addr];
        n_val   = ((row == kk) ? FOUR_Q16 : 21'sd0) - ma_rd;
        // adjugate entry split into a signed high part and an unsigned low part
        c_half  = seq.term[0] ? $signed({12'b0, c_rd[20:0]}) : opnd_t'($signed(c_rd[42:21]));

        mctl     = '0;
        mctl.en  = seq.issue;
        mctl.clr = seq.term == 3'd0;
        op_a     = '0;
        op_b     = '0;
        case (seq.phase)
            PH_A:
            begin
                op_a = opnd_t'(omega_reg[seq.ent]);
                op_b = $signed({2'b0, dt_reg});
            end
            PH_C:
            begin
                op_a     = opnd_t'(ma_rd);
                op_b     = opnd_t'(mb_reg[cs.ib]);
                mctl.neg = cs.neg;
            end
            PH_D:
            begin
                op_a     = opnd_t'(ma_rd);
                op_b     = c_half;
                mctl.shl = !seq.term[0];
            end
            PH_X:
            begin
                op_a     = opnd_t'(n_val);
                op_b     = c_half;
                mctl.shl = !seq.term[0];
            end
            PH_R:
            begin
                op_a     = opnd_t'(att_reg[mat_idx(row, kk)]);
                op_b     = opnd_t'(p_reg[mat_idx(kk, col)]);
                mctl.shr = 1'b1;
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // write-back values
    always_comb
    begin
        a_full = acc >>> 16;
        if (a_full > A_MAX)
        begin
            a_sat = 20'(A_MAX);
        end
        else if (a_full < A_MIN)
        begin
            a_sat = 20'(A_MIN);
        end
        else
        begin
            a_sat = a_full[19:0];
        end
        m_new = ((row == col) ? TWO_Q16 : 21'sd0) - mval_t'(a_sat);
        if (acc > ATT_MAX)
        begin
            r_new = word_t'(ATT_MAX);
        end
        else if (acc < ATT_MIN)
        begin
            r_new = word_t'(ATT_MIN);
        end
        else
        begin
            r_new = acc[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            omega_reg[0] <= rate.omega_00;
            omega_reg[1] <= rate.omega_01;
            omega_reg[2] <= rate.omega_02;
            omega_reg[3] <= rate.omega_10;
            omega_reg[4] <= rate.omega_11;
            omega_reg[5] <= rate.omega_12;
            omega_reg[6] <= rate.omega_20;
            omega_reg[7] <= rate.omega_21;
            omega_reg[8] <= rate.omega_22;
        end
        if (seq.wb)
        begin
            case (seq.phase)
                PH_A:
                begin
                    ma_reg[seq.ent] <= m_new;
                    mb_reg[seq.ent] <= m_new;
                end
                PH_C:
                begin
                    c_reg[seq.ent] <= acc[42:0];
                end
                PH_D:
                begin
                    d_reg <= acc;
                end
                PH_R:
                begin
                    nr_reg[seq.ent] <= r_new;
                end
                default:
                begin
                    d_reg <= d_reg;
                end
            endcase
        end
        if (seq.p_we)
        begin
            p_reg[seq.ent] <= quo;
        end
        if (seq.done_load)
        begin
            out_ok_reg <= ok_reg;
            for (int j = 0; j < 9; j = j + 1)
            begin
                out_att_reg[j] <= ok_reg ? nr_reg[j] : att_reg[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg        <= DT_RESET;
            ok_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < 9; j = j + 1)
            begin
                att_reg[j] <= (j % 4 == 0) ? ONE_Q30 : 32'sd0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                dt_reg <= cfg_wdata;
            end
            if (seq.wb && (seq.phase == PH_D))
            begin
                ok_reg <= !det_zero;
            end
            if (seq.done_load)
            begin
                out_valid_reg <= 1'b1;
                if (ok_reg)
                begin
                    for (int j = 0; j < 9; j = j + 1)
                    begin
                        att_reg[j] <= nr_reg[j];
                    end
                end
            end
            else if (attitude.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign attitude.valid      = out_valid_reg;
    assign attitude.updated_ok = out_ok_reg;
    assign attitude.att_00     = out_att_reg[0];
    assign attitude.att_01     = out_att_reg[1];
    assign attitude.att_02     = out_att_reg[2];
    assign attitude.att_10     = out_att_reg[3];
    assign attitude.att_11     = out_att_reg[4];
    assign attitude.att_12     = out_att_reg[5];
    assign attitude.att_20     = out_att_reg[6];
    assign attitude.att_21     = out_att_reg[7];
    assign attitude.att_22     = out_att_reg[8];

    `AMP_ASSERT_NEVER(a_div_overlap, seq.div_start && div_busy, "divider restarted while busy")
    `AMP_ASSERT(a_result_shown, seq.done_load |=> attitude.valid, "finished item not presented")
    `AMP_ASSERT(a_singular_keeps, (seq.done_load && !ok_reg) |=> $stable(att_reg[4]), "singular item changed attitude")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import amp_pkg::*;
();

    localparam int CLK_PERIOD  = 20;
    localparam int DRAIN_WAIT  = 600;
    localparam int HOLD_CYCLES = 3000;
    localparam int STALL_LIMIT = 20000;
    localparam int RAND_PER_DT = 160;
    localparam logic [30:0] DT_UNIT = 31'd65536;
    localparam logic [30:0] DT_MAX  = 31'h7fff_ffff;

    typedef logic signed [31:0] rate9_t [9];

    typedef struct {
        bit                 ok;
        logic signed [31:0] att [9];
    } att_res_t;

    typedef struct {
        rate9_t   w;
        bit       typed;
        att_res_t res;
    } rate_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [30:0] cfg_wdata;

    amp_in_if  rate_bus ();
    amp_out_if att_bus ();

    attitude_matrix_pade_update u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .rate     (rate_bus),
        .attitude (att_bus)
    );

    // predictor copy of the block state
    logic [30:0] dt_q16;
    longint      att_state [9];

    att_res_t att_expected_q [$];
    int       err_cnt;
    int       items_in;
    int       idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic longint clamp64(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // quotient in Q2.30, truncated toward zero, saturated at magnitude 2
    function automatic longint quot_q30(longint x, longint d);
        longint unsigned ux;
        longint unsigned ud;
        longint unsigned q;
        longint unsigned rm;
        longint unsigned mg;
        bit              neg;
        neg = (x < 0) != (d < 0);
        ux  = (x < 0) ? -x : x;
        ud  = (d < 0) ? -d : d;
        q   = ux / ud;
        rm  = ux % ud;
        if (q >= 2)
            return neg ? -64'sd2147483648 : 64'sd2147483647;
        mg = q;
        for (int b = 0; b < 30; b++)
        begin
            rm = rm << 1;
            mg = mg << 1;
            if (rm >= ud)
            begin
                rm = rm - ud;
                mg = mg | 64'd1;
            end
        end
        return neg ? -$signed(mg) : $signed(mg);
    endfunction

    function automatic att_res_t cayley_update(rate9_t w);
        longint   m [3][3];
        longint   n [3][3];
        longint   c [3][3];
        longint   p [3][3];
        longint   nr [9];
        longint   a;
        longint   dg;
        longint   d;
        longint   x;
        longint   s;
        att_res_t r;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                a = longint'(w[i * 3 + j]) * longint'({33'd0, dt_q16});
                a = clamp64(a >>> 16, -64'sd524288, 64'sd524287);
                dg = (i == j) ? 64'sd131072 : 64'sd0;
                n[i][j] = dg + a;
                m[i][j] = dg - a;
            end
        c[0][0] = m[1][1] * m[2][2] - m[2][1] * m[1][2];
        c[1][0] = -(m[1][0] * m[2][2] - m[2][0] * m[1][2]);
        c[2][0] = m[1][0] * m[2][1] - m[2][0] * m[1][1];
        c[0][1] = -(m[0][1] * m[2][2] - m[2][1] * m[0][2]);
        c[1][1] = m[0][0] * m[2][2] - m[2][0] * m[0][2];
        c[2][1] = -(m[0][0] * m[2][1] - m[2][0] * m[0][1]);
        c[0][2] = m[0][1] * m[1][2] - m[1][1] * m[0][2];
        c[1][2] = -(m[0][0] * m[1][2] - m[1][0] * m[0][2]);
        c[2][2] = m[0][0] * m[1][1] - m[1][0] * m[0][1];
        d = m[0][0] * c[0][0] + m[0][1] * c[1][0] + m[0][2] * c[2][0];
        r.ok = (d != 0);
        if (r.ok)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    x = 0;
                    for (int k = 0; k < 3; k++)
                        x += n[i][k] * c[k][j];
                    p[i][j] = quot_q30(x, d);
                end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    s = 0;
                    for (int k = 0; k < 3; k++)
                        s += (att_state[i * 3 + k] * p[k][j]) >>> 30;
                    nr[i * 3 + j] = clamp64(s, -64'sd2147483648, 64'sd2147483647);
                end
            for (int i = 0; i < 9; i++)
                att_state[i] = nr[i];
        end
        for (int i = 0; i < 9; i++)
            r.att[i] = att_state[i][31:0];
        return r;
    endfunction

    function automatic att_res_t identity_res(bit ok);
        att_res_t r;
        r.ok = ok;
        for (int i = 0; i < 9; i++)
            r.att[i] = (i % 4 == 0) ? ONE_Q30 : 32'sd0;
        return r;
    endfunction

    function automatic rate9_t fill_rate(logic signed [31:0] v);
        rate9_t w;
        for (int i = 0; i < 9; i++)
            w[i] = v;
        return w;
    endfunction

    function automatic logic signed [31:0] small_rate();
        return $signed($urandom_range(0, 524288)) - 32'sd262144;
    endfunction

    function automatic rate9_t random_rate(bit unit_dt);
        rate9_t w;
        int     kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 9; i++)
            w[i] = 32'sd0;
        if (kind < 50)
        begin
            for (int i = 0; i < 9; i++)
                w[i] = small_rate();
        end
        else if (kind < 70)
        begin
            // proper rotation rates: skew-symmetric, zero diagonal
            w[1] = small_rate();
            w[2] = small_rate();
            w[5] = small_rate();
            w[3] = -w[1];
            w[6] = -w[2];
            w[7] = -w[5];
        end
        else if (kind < 85)
        begin
            for (int i = 0; i < 9; i++)
                w[i] = $urandom;
        end
        else if (kind < 93)
        begin
            for (int i = 0; i < 9; i++)
                w[i] = small_rate();
            w[$urandom_range(0, 8)] = $urandom;
        end
        else
        begin
            // zero row of M when dt is 1.0, otherwise a sparse small rate
            for (int i = 0; i < 9; i++)
                w[i] = ($urandom_range(0, 1) == 1) ? small_rate() : 32'sd0;
            if (unit_dt)
            begin
                int r;
                r = $urandom_range(0, 2);
                for (int j = 0; j < 3; j++)
                    w[r * 3 + j] = (r == j) ? 32'sd131072 : 32'sd0;
            end
        end
        return w;
    endfunction

    int burst_left;

    task automatic send_rate(rate9_t w, bit typed, att_res_t typed_res);
        att_res_t pred;
        rate_bus.valid    <= 1'b1;
        rate_bus.omega_00 <= w[0];
        rate_bus.omega_01 <= w[1];
        rate_bus.omega_02 <= w[2];
        rate_bus.omega_10 <= w[3];
        rate_bus.omega_11 <= w[4];
        rate_bus.omega_12 <= w[5];
        rate_bus.omega_20 <= w[6];
        rate_bus.omega_21 <= w[7];
        rate_bus.omega_22 <= w[8];
        do
            @(posedge clk);
        while (!rate_bus.ready);
        pred = cayley_update(w);
        att_expected_q.push_back(typed ? typed_res : pred);
        items_in++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            rate_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        rate_bus.valid <= 1'b0;
        while (att_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_dt(logic [30:0] v);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        dt_q16 = v;
    endtask

    task automatic run_random(int cnt);
        att_res_t none;
        none = identity_res(1'b1);
        for (int i = 0; i < cnt; i++)
            send_rate(random_rate(dt_q16 == DT_UNIT), 1'b0, none);
    endtask

    rate_row_t dir_rows [$];

    task automatic build_rows();
        rate_row_t row;
        row.typed = 1'b0;
        row.res   = identity_res(1'b1);
        // singular: first row of M is zero
        row.w = fill_rate(32'sd0);
        row.w[0] = 32'sd131072;
        row.typed = 1'b1;
        row.res   = identity_res(1'b0);
        dir_rows.push_back(row);
        row.w = fill_rate(32'sd0);
        row.res = identity_res(1'b1);
        dir_rows.push_back(row);
        row.typed = 1'b0;
        row.w = fill_rate(32'sh7fff_ffff);
        dir_rows.push_back(row);
        row.w = fill_rate(32'sh8000_0000);
        dir_rows.push_back(row);
        for (int i = 0; i < 9; i++)
            row.w[i] = (i % 2 == 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
        dir_rows.push_back(row);
        row.w = fill_rate(32'sd0);
        row.w[1] = -32'sd6554;
        row.w[3] = 32'sd6554;
        dir_rows.push_back(row);
        // singular in the last row
        row.w = fill_rate(32'sd0);
        row.w[8] = 32'sd131072;
        dir_rows.push_back(row);
        row.w = fill_rate(32'sd0);
        row.w[4] = -32'sd65536;
        dir_rows.push_back(row);
        row.w = fill_rate(32'sd65536);
        dir_rows.push_back(row);
        row.w = fill_rate(-32'sd1);
        dir_rows.push_back(row);
        row.w = fill_rate(32'sd0);
        row.w[1] = 32'sh7fff_ffff;
        row.w[3] = 32'sh8000_0000;
        row.w[5] = 32'sh8000_0000;
        row.w[7] = 32'sh7fff_ffff;
        dir_rows.push_back(row);
        row.w = fill_rate(32'sh5555_5555);
        row.w[2] = 32'shaaaa_aaaa;
        row.w[6] = 32'shaaaa_aaaa;
        dir_rows.push_back(row);
    endtask

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rate_bus.valid = 1'b0;
        rate_bus.omega_00 = '0;
        rate_bus.omega_01 = '0;
        rate_bus.omega_02 = '0;
        rate_bus.omega_10 = '0;
        rate_bus.omega_11 = '0;
        rate_bus.omega_12 = '0;
        rate_bus.omega_20 = '0;
        rate_bus.omega_21 = '0;
        rate_bus.omega_22 = '0;
        dt_q16     = DT_RESET;
        burst_left = 0;
        items_in   = 0;
        for (int i = 0; i < 9; i++)
            att_state[i] = (i % 4 == 0) ? 64'sd1073741824 : 64'sd0;
        build_rows();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero rate at the reset interval keeps the identity
        send_rate(fill_rate(32'sd0), 1'b1, identity_res(1'b1));
        write_dt(DT_UNIT);
        foreach (dir_rows[i])
            send_rate(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
        run_random(RAND_PER_DT);
        write_dt(DT_RESET);
        run_random(RAND_PER_DT);
        write_dt(31'd1);
        run_random(RAND_PER_DT / 2);
        write_dt(DT_MAX);
        run_random(RAND_PER_DT / 2);
        write_dt(31'd0);
        run_random(RAND_PER_DT / 2);
        write_dt(31'($urandom_range(1, 262144)));
        run_random(RAND_PER_DT);
        write_dt(DT_UNIT);
        run_random(RAND_PER_DT);

        wait_idle();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver: randomly switching stall patterns, with one long hold-off once 40 items are in
    initial
    begin
        bit held;
        int mode;
        held = 1'b0;
        att_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && items_in >= 40)
            begin
                held = 1'b1;
                att_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = ($urandom_range(0, 255) == 0) ? $urandom_range(0, 2) : mode;
            case (mode)
                0:       att_bus.ready <= 1'b1;
                1:       att_bus.ready <= ($urandom_range(0, 9) < 7);
                default: att_bus.ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // result checker and watchdog
    initial
    begin
        att_res_t exp_res;
        logic signed [31:0] got [9];
        err_cnt     = 0;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((rate_bus.valid && rate_bus.ready) || (att_bus.valid && att_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (rst_n && att_bus.valid && att_bus.ready)
            begin
                got = '{att_bus.att_00, att_bus.att_01, att_bus.att_02,
                        att_bus.att_10, att_bus.att_11, att_bus.att_12,
                        att_bus.att_20, att_bus.att_21, att_bus.att_22};
                if (att_expected_q.size() == 0)
                begin
                    $error("unexpected item on attitude output");
                    err_cnt++;
                end
                else
                begin
                    exp_res = att_expected_q.pop_front();
                    if (att_bus.updated_ok !== exp_res.ok)
                    begin
                        $error("updated_ok expected %0d actual %0d", exp_res.ok,
                               att_bus.updated_ok);
                        err_cnt++;
                    end
                    for (int i = 0; i < 9; i++)
                        if (got[i] !== exp_res.att[i])
                        begin
                            $error("att_%0d%0d expected %0d actual %0d", i / 3, i % 3,
                                   exp_res.att[i], got[i]);
                            err_cnt++;
                        end
                end
            end
        end
    end

endmodule
